// ===== rtl/free_space_map_first_fit_unit_macros.svh =====
// assertion macros shared by the free-space map checker
// no dependencies; include by bare file name
`ifndef FREE_SPACE_MAP_FIRST_FIT_UNIT_MACROS_SVH
`define FREE_SPACE_MAP_FIRST_FIT_UNIT_MACROS_SVH

// property checked only while out of reset
`define FSMFF_ASSERT(name, clk, rstn, prop, msg) \
    name: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// property that also holds across reset
`define FSMFF_ASSERT_ALWAYS(name, clk, prop, msg) \
    name: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== rtl/fsmff_pkg.sv =====
// types, constants and the category function for the free-space map
// no dependencies
`timescale 1ns / 1ps

package fsmff_pkg;

    localparam int PAGES      = 4096;
    localparam int PAGE_BYTES = 8192;
    // category of a completely free page
    localparam int CAT_SCALE  = 255;

    // one memory word holds the categories of this many pages
    localparam int ROW_ENTRIES = 64;
    localparam int ROWS        = PAGES / ROW_ENTRIES;
    localparam int ROW_W       = $clog2(ROWS);
    localparam int COL_W       = $clog2(ROW_ENTRIES);
    localparam int CNT_W       = $clog2(PAGES + 1);

    typedef logic [7:0]          cat_t;
    typedef logic [11:0]         page_idx_t;
    typedef logic [12:0]         total_t;
    typedef logic [ROW_W-1:0]    row_idx_t;
    typedef logic [ROW_W:0]      scan_t;
    typedef logic [COL_W-1:0]    col_idx_t;
    typedef logic [CNT_W-1:0]    cnt_t;
    typedef cat_t [ROW_ENTRIES-1:0] row_t;

    typedef enum logic [1:0] {
        CMD_UPDATE = 2'd0,
        CMD_SET    = 2'd1,
        CMD_FIND   = 2'd2,
        CMD_GET    = 2'd3
    } cmd_t;

    typedef struct packed {
        cmd_t        cmd;
        page_idx_t   page_index;
        logic [15:0] byte_count;
        cat_t        category_value;
    } in_t;

    typedef struct packed {
        logic      found;
        page_idx_t result_page;
        cat_t      result_category;
        total_t    page_total;
    } out_t;

    typedef struct packed {
        logic     hit;
        col_idx_t col;
    } match_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_FETCH,
        ST_APPLY,
        ST_SCAN,
        ST_DONE
    } state_t;

    function automatic cat_t bytes_to_cat(input logic [15:0] bytes);
        logic [15:0] clamped;
        logic [23:0] prod;
        clamped = (32'(bytes) > PAGE_BYTES) ? 16'(PAGE_BYTES) : bytes;
        prod    = 24'(clamped) * 24'(CAT_SCALE);
        return cat_t'(prod / PAGE_BYTES);
    endfunction

endpackage

// ===== rtl/fsmff_row_ram.sv =====
// single-port synchronous ram with registered read data
// no dependencies
`timescale 1ns / 1ps

module fsmff_row_ram #(
    parameter int DEPTH = 64,
    parameter int WIDTH = 512
) (
    input  logic                     aclk,
    input  logic                     en,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            if (we) begin
                mem[addr] <= wdata;
            end else begin
                rdata_reg <= mem[addr];
            end
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== rtl/fsmff_row_match.sv =====
// first-fit search within one memory row: compare and priority encode
// depends on fsmff_pkg
`timescale 1ns / 1ps

module fsmff_row_match (
    input  fsmff_pkg::row_t   row,
    input  fsmff_pkg::cat_t   need,
    output fsmff_pkg::match_t result
);

    logic [fsmff_pkg::ROW_ENTRIES-1:0] fits;

    always_comb begin
        for (int i = 0; i < fsmff_pkg::ROW_ENTRIES; i++) begin
            fits[i] = (row[i] != '0) && (row[i] >= need);
        end
    end

    // lowest fitting entry wins
    always_comb begin
        result.hit = |fits;
        result.col = '0;
        for (int i = fsmff_pkg::ROW_ENTRIES - 1; i >= 0; i--) begin
            if (fits[i]) begin
                result.col = fsmff_pkg::col_idx_t'(i);
            end
        end
    end

endmodule

// ===== rtl/free_space_map_first_fit_unit.sv =====
// Free-space map with first-fit search. Categories live in a 64-word RAM, 64 pages of
// 8 bits per word, with one valid flip-flop per word so reset needs no clearing pass
// (a word never written reads as all zero, and a zero category behaves as never written).
// Update, set and get pass from input beat to result beat through command decode, RAM read,
// modify/write and output load. Find walks the RAM one word per cycle through its single
// read port and stops at the first fitting word, or after the last of the 64 words on a miss.
// One item is worked on at a time; the output register lets a new input beat be taken while
// a result waits.
// depends on fsmff_pkg, fsmff_row_ram, fsmff_row_match
`timescale 1ns / 1ps

module free_space_map_first_fit_unit (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  fsmff_pkg::in_t     s_data,
    output logic               m_valid,
    input  logic               m_ready,
    output fsmff_pkg::out_t    m_data
);

    fsmff_pkg::state_t  state_reg, state_next;
    fsmff_pkg::in_t     item_reg, item_next;
    fsmff_pkg::cat_t    cat_reg, cat_next;
    logic               res_found_reg, res_found_next;
    fsmff_pkg::page_idx_t res_page_reg, res_page_next;
    fsmff_pkg::cat_t    res_cat_reg, res_cat_next;
    logic [fsmff_pkg::ROWS-1:0] row_valid_reg, row_valid_next;
    fsmff_pkg::cnt_t    pages_reg, pages_next;
    fsmff_pkg::scan_t   scan_row_reg, scan_row_next;
    logic               pend_valid_reg, pend_valid_next;
    fsmff_pkg::row_idx_t pend_row_reg, pend_row_next;
    logic               m_valid_reg, m_valid_next;
    fsmff_pkg::out_t    m_data_reg, m_data_next;

    logic                ram_en;
    logic                ram_we;
    fsmff_pkg::row_idx_t ram_addr;
    fsmff_pkg::row_t     ram_wdata;
    fsmff_pkg::row_t     ram_rdata;

    fsmff_pkg::row_idx_t item_row;
    fsmff_pkg::col_idx_t item_col;
    logic                in_range;
    fsmff_pkg::row_t     base_row;
    fsmff_pkg::row_t     merged_row;
    fsmff_pkg::row_t     scan_data;
    fsmff_pkg::match_t   match;
    logic                issue_more;

    fsmff_row_ram #(
        .DEPTH (fsmff_pkg::ROWS),
        .WIDTH ($bits(fsmff_pkg::row_t))
    ) u_ram (
        .aclk  (aclk),
        .en    (ram_en),
        .we    (ram_we),
        .addr  (ram_addr),
        .wdata (ram_wdata),
        .rdata (ram_rdata)
    );

    // words never written read as all zero
    assign scan_data = row_valid_reg[pend_row_reg] ? ram_rdata : '0;

    fsmff_row_match u_match (
        .row    (scan_data),
        .need   (cat_reg),
        .result (match)
    );

    assign item_row   = fsmff_pkg::row_idx_t'(item_reg.page_index >> fsmff_pkg::COL_W);
    assign item_col   = fsmff_pkg::col_idx_t'(item_reg.page_index);
    assign in_range   = 32'(item_reg.page_index) < fsmff_pkg::PAGES;
    assign issue_more = 32'(scan_row_reg) < fsmff_pkg::ROWS;

    always_comb begin
        base_row           = row_valid_reg[item_row] ? ram_rdata : '0;
        merged_row         = base_row;
        merged_row[item_col] = cat_reg;
    end

    always_comb begin
        state_next      = state_reg;
        item_next       = item_reg;
        cat_next        = cat_reg;
        res_found_next  = res_found_reg;
        res_page_next   = res_page_reg;
        res_cat_next    = res_cat_reg;
        row_valid_next  = row_valid_reg;
        pages_next      = pages_reg;
        scan_row_next   = scan_row_reg;
        pend_valid_next = pend_valid_reg;
        pend_row_next   = pend_row_reg;
        m_valid_next    = m_valid_reg;
        m_data_next     = m_data_reg;
        ram_en          = 1'b0;
        ram_we          = 1'b0;
        ram_addr        = item_row;
        ram_wdata       = merged_row;

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        unique case (state_reg)
            fsmff_pkg::ST_IDLE: begin
                if (s_valid) begin
                    item_next  = s_data;
                    state_next = fsmff_pkg::ST_FETCH;
                end
            end
            fsmff_pkg::ST_FETCH: begin
                cat_next = (item_reg.cmd == fsmff_pkg::CMD_SET) ? item_reg.category_value
                         : fsmff_pkg::bytes_to_cat(item_reg.byte_count);
                res_found_next = 1'b0;
                res_page_next  = '0;
                res_cat_next   = '0;
                if (item_reg.cmd == fsmff_pkg::CMD_FIND) begin
                    scan_row_next   = '0;
                    pend_valid_next = 1'b0;
                    state_next      = fsmff_pkg::ST_SCAN;
                end else begin
                    ram_en     = 1'b1;
                    state_next = fsmff_pkg::ST_APPLY;
                end
            end
            fsmff_pkg::ST_APPLY: begin
                if (item_reg.cmd == fsmff_pkg::CMD_GET) begin
                    if (in_range && row_valid_reg[item_row]) begin
                        res_cat_next = ram_rdata[item_col];
                    end
                end else if (in_range) begin
                    ram_en                   = 1'b1;
                    ram_we                   = 1'b1;
                    row_valid_next[item_row] = 1'b1;
                    if (fsmff_pkg::cnt_t'(item_reg.page_index) >= pages_reg) begin
                        pages_next = fsmff_pkg::cnt_t'(item_reg.page_index)
                                   + fsmff_pkg::cnt_t'(1);
                    end
                end
                state_next = fsmff_pkg::ST_DONE;
            end
            fsmff_pkg::ST_SCAN: begin
                // read one word ahead, judge the word read last cycle
                ram_addr        = fsmff_pkg::row_idx_t'(scan_row_reg);
                ram_en          = issue_more;
                pend_valid_next = issue_more;
                pend_row_next   = fsmff_pkg::row_idx_t'(scan_row_reg);
                if (issue_more) begin
                    scan_row_next = scan_row_reg + fsmff_pkg::scan_t'(1);
                end
                if (pend_valid_reg && match.hit) begin
                    res_found_next = 1'b1;
                    res_page_next  = fsmff_pkg::page_idx_t'({pend_row_reg, match.col});
                    state_next     = fsmff_pkg::ST_DONE;
                end else if (pend_valid_reg &&
                             pend_row_reg == fsmff_pkg::row_idx_t'(fsmff_pkg::ROWS - 1)) begin
                    state_next = fsmff_pkg::ST_DONE;
                end
            end
            fsmff_pkg::ST_DONE: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next                = 1'b1;
                    m_data_next.found           = res_found_reg;
                    m_data_next.result_page     = res_page_reg;
                    m_data_next.result_category = res_cat_reg;
                    m_data_next.page_total      = fsmff_pkg::total_t'(pages_reg);
                    state_next                  = fsmff_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = fsmff_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= fsmff_pkg::ST_IDLE;
            row_valid_reg  <= '0;
            pages_reg      <= '0;
            pend_valid_reg <= 1'b0;
            m_valid_reg    <= 1'b0;
        end else begin
            state_reg      <= state_next;
            row_valid_reg  <= row_valid_next;
            pages_reg      <= pages_next;
            pend_valid_reg <= pend_valid_next;
            m_valid_reg    <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        item_reg      <= item_next;
        cat_reg       <= cat_next;
        res_found_reg <= res_found_next;
        res_page_reg  <= res_page_next;
        res_cat_reg   <= res_cat_next;
        scan_row_reg  <= scan_row_next;
        pend_row_reg  <= pend_row_next;
        m_data_reg    <= m_data_next;
    end

    assign s_ready = (state_reg == fsmff_pkg::ST_IDLE);
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

// ===== rtl/fsmff_checker.sv =====
// port-level checks for the free-space map, bound to the top level
// depends on fsmff_pkg and free_space_map_first_fit_unit_macros.svh
`timescale 1ns / 1ps
`include "free_space_map_first_fit_unit_macros.svh"

module fsmff_checker (
    input logic            aclk,
    input logic            aresetn,
    input logic            s_valid,
    input logic            s_ready,
    input fsmff_pkg::in_t  s_data,
    input logic            m_valid,
    input logic            m_ready,
    input fsmff_pkg::out_t m_data
);

    // a stalled result beat holds
    `FSMFF_ASSERT(a_out_hold, aclk, aresetn, m_valid && !m_ready |=> m_valid && $stable(m_data), "result beat changed while stalled")

    // a miss reports page zero
    `FSMFF_ASSERT(a_miss_page, aclk, aresetn, m_valid && !m_data.found |-> m_data.result_page == '0, "miss with nonzero page")

    // find and get results never mix
    `FSMFF_ASSERT(a_no_mix, aclk, aresetn, m_valid |-> !(m_data.found && m_data.result_category != '0), "find and get fields both set")

    // reset empties the output register
    `FSMFF_ASSERT_ALWAYS(a_reset_out, aclk, !aresetn |=> !m_valid, "result beat right after reset")

    // the page count never passes the table size
    `FSMFF_ASSERT(a_total_max, aclk, aresetn, m_valid |-> 32'(m_data.page_total) <= fsmff_pkg::PAGES, "page total beyond table")

endmodule

bind free_space_map_first_fit_unit fsmff_checker u_fsmff_checker (.*);

// ===== verif/free_space_map_first_fit_unit_test.sv =====
// self-checking bench for the free-space map: directed table, then weighted random traffic
// predicts untyped replies from its own page table copy; depends on fsmff_pkg and the unit
`timescale 1ns / 1ps

module free_space_map_first_fit_unit_test;

    localparam int RANDOM_BEATS = 650;
    localparam int HOLD_AFTER   = 150;   // long receiver hold-off starts after this many beats
    localparam int HOLD_CYCLES  = 300;
    localparam int DRAIN_AT     = 350;   // sender waits here until no reply is pending
    localparam int TAIL_CYCLES  = 100;

    typedef struct {
        fsmff_pkg::in_t  beat;
        bit              known;
        fsmff_pkg::out_t reply;
    } dir_row_t;

    typedef struct {
        fsmff_pkg::in_t  beat;
        fsmff_pkg::out_t reply;
    } pending_t;

    logic            aclk;
    logic            aresetn;
    logic            s_valid;
    logic            s_ready;
    fsmff_pkg::in_t  s_data;
    logic            m_valid;
    logic            m_ready;
    fsmff_pkg::out_t m_data;

    // predictor state
    fsmff_pkg::cat_t   cat_mem [fsmff_pkg::PAGES];
    bit                page_written [fsmff_pkg::PAGES];
    fsmff_pkg::total_t pages_used;

    dir_row_t dir_rows [$];
    dir_row_t beat_tags [$];
    pending_t pending_replies [$];

    int     errors;
    int     beats_accepted;
    logic [11:0] last_page;

    free_space_map_first_fit_unit uut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    always begin
        aclk = 1'b1;
        #5;
        aclk = 1'b0;
        #5;
    end

    function automatic fsmff_pkg::cat_t bytes_to_category(logic [15:0] bytes);
        logic [23:0] scaled;
        scaled = (bytes > 16'(fsmff_pkg::PAGE_BYTES)) ? 24'(fsmff_pkg::PAGE_BYTES)
                                                       : 24'(bytes);
        scaled = scaled * 24'd255;
        return fsmff_pkg::cat_t'(scaled / 24'(fsmff_pkg::PAGE_BYTES));
    endfunction

    // applies one beat to the shadow table and returns the reply it must produce
    function automatic fsmff_pkg::out_t predict_map_reply(fsmff_pkg::in_t b);
        fsmff_pkg::out_t r;
        fsmff_pkg::cat_t need;
        fsmff_pkg::cat_t wcat;
        int i;
        r = '0;
        case (b.cmd)
            fsmff_pkg::CMD_UPDATE, fsmff_pkg::CMD_SET: begin
                wcat = (b.cmd == fsmff_pkg::CMD_SET) ? b.category_value
                                                     : bytes_to_category(b.byte_count);
                cat_mem[b.page_index] = wcat;
                page_written[b.page_index] = 1'b1;
                if ({1'b0, b.page_index} >= pages_used)
                    pages_used = {1'b0, b.page_index} + 13'd1;
            end
            fsmff_pkg::CMD_FIND: begin
                need = bytes_to_category(b.byte_count);
                for (i = 0; i < fsmff_pkg::PAGES; i++) begin
                    // a zero category never fits, even for a zero requirement
                    if (page_written[i] && cat_mem[i] != 8'd0 && cat_mem[i] >= need) begin
                        r.found = 1'b1;
                        r.result_page = fsmff_pkg::page_idx_t'(i);
                        break;
                    end
                end
            end
            fsmff_pkg::CMD_GET: begin
                if (page_written[b.page_index])
                    r.result_category = cat_mem[b.page_index];
            end
        endcase
        r.page_total = pages_used;
        return r;
    endfunction

    function automatic dir_row_t mk_row(fsmff_pkg::cmd_t c, int page, int bytes, int cv,
                                        bit known, bit f, int rp, int rc, int tot);
        dir_row_t d;
        d.beat.cmd              = c;
        d.beat.page_index       = fsmff_pkg::page_idx_t'(page);
        d.beat.byte_count       = 16'(bytes);
        d.beat.category_value   = fsmff_pkg::cat_t'(cv);
        d.known                 = known;
        d.reply.found           = f;
        d.reply.result_page     = fsmff_pkg::page_idx_t'(rp);
        d.reply.result_category = fsmff_pkg::cat_t'(rc);
        d.reply.page_total      = fsmff_pkg::total_t'(tot);
        return d;
    endfunction

    function automatic fsmff_pkg::in_t random_beat();
        fsmff_pkg::in_t b;
        int r;
        r = $urandom_range(0, 99);
        if (r < 30)
            b.cmd = fsmff_pkg::CMD_UPDATE;
        else if (r < 55)
            b.cmd = fsmff_pkg::CMD_SET;
        else if (r < 80)
            b.cmd = fsmff_pkg::CMD_FIND;
        else
            b.cmd = fsmff_pkg::CMD_GET;
        r = $urandom_range(0, 9);
        if (r < 5)
            b.page_index = fsmff_pkg::page_idx_t'($urandom_range(0, 63));
        else if (r < 7)
            b.page_index = fsmff_pkg::page_idx_t'($urandom_range(0, 4095));
        else if (r < 9)
            b.page_index = last_page;
        else
            b.page_index = fsmff_pkg::page_idx_t'($urandom_range(4032, 4095));
        r = $urandom_range(0, 9);
        if (r == 0)
            b.byte_count = 16'd0;
        else if (r == 1)
            b.byte_count = 16'(fsmff_pkg::PAGE_BYTES);
        else if (r == 2)
            b.byte_count = 16'($urandom_range(fsmff_pkg::PAGE_BYTES + 1, 65535));
        else if (r == 3)
            b.byte_count = 16'($urandom_range(7900, fsmff_pkg::PAGE_BYTES));
        else
            b.byte_count = 16'($urandom_range(0, fsmff_pkg::PAGE_BYTES));
        // plenty of tiny categories so a find has to search past the low pages
        r = $urandom_range(0, 9);
        if (r < 3)
            b.category_value = fsmff_pkg::cat_t'($urandom_range(0, 3));
        else if (r == 3)
            b.category_value = 8'd255;
        else
            b.category_value = fsmff_pkg::cat_t'($urandom_range(0, 255));
        if (b.cmd == fsmff_pkg::CMD_UPDATE || b.cmd == fsmff_pkg::CMD_SET)
            last_page = b.page_index;
        return b;
    endfunction

    task automatic send_beat(fsmff_pkg::in_t b, bit known, fsmff_pkg::out_t typed);
        dir_row_t tag;
        tag.beat  = b;
        tag.known = known;
        tag.reply = typed;
        @(negedge aclk);
        beat_tags.push_back(tag);
        s_valid <= 1'b1;
        s_data  <= b;
        do @(posedge aclk); while (!s_ready);
    endtask

    task automatic idle_gap(int cycles);
        repeat (cycles) begin
            @(negedge aclk);
            s_valid <= 1'b0;
        end
    endtask

    // scoreboard: result beat checked before the input beat of the same edge is predicted
    always @(posedge aclk) begin
        pending_t p;
        dir_row_t tag;
        fsmff_pkg::out_t want;
        if (aresetn) begin
            if (m_valid && m_ready) begin
                if (pending_replies.size() == 0) begin
                    errors++;
                    if (errors <= 10)
                        $display("result beat with nothing pending: %0d/%0d/%0d/%0d",
                                 m_data.found, m_data.result_page, m_data.result_category,
                                 m_data.page_total);
                end else begin
                    p = pending_replies.pop_front();
                    if (m_data.found !== p.reply.found ||
                        m_data.result_page !== p.reply.result_page ||
                        m_data.result_category !== p.reply.result_category ||
                        m_data.page_total !== p.reply.page_total) begin
                        errors++;
                        if (errors <= 10) begin
                            $display("mismatch cmd=%s page=%0d bytes=%0d cat=%0d",
                                     p.beat.cmd.name(), p.beat.page_index,
                                     p.beat.byte_count, p.beat.category_value);
                            $display("  expected %0d/%0d/%0d/%0d got %0d/%0d/%0d/%0d",
                                     p.reply.found, p.reply.result_page,
                                     p.reply.result_category, p.reply.page_total,
                                     m_data.found, m_data.result_page,
                                     m_data.result_category, m_data.page_total);
                        end
                    end
                end
            end
            if (s_valid && s_ready) begin
                tag = beat_tags.pop_front();
                want = predict_map_reply(s_data);
                p.beat  = s_data;
                p.reply = tag.known ? tag.reply : want;
                pending_replies.push_back(p);
                beats_accepted++;
            end
        end
    end

    // receiver: picks a new stall mode for each random span, one long hold-off mid-run
    initial begin
        int mode;
        int span;
        bit hold_done;
        hold_done = 1'b0;
        m_ready <= 1'b0;
        @(posedge aresetn);
        forever begin
            mode = $urandom_range(0, 3);
            span = $urandom_range(16, 96);
            repeat (span) begin
                @(negedge aclk);
                if (!hold_done && beats_accepted >= HOLD_AFTER) begin
                    hold_done = 1'b1;
                    m_ready <= 1'b0;
                    repeat (HOLD_CYCLES) @(negedge aclk);
                end else begin
                    case (mode)
                        0: m_ready <= 1'b1;
                        1: m_ready <= 1'($urandom_range(0, 1));
                        2: m_ready <= ($urandom_range(0, 3) == 0);
                        default: m_ready <= ($urandom_range(0, 7) != 0);
                    endcase
                end
            end
        end
    end

    initial begin
        int i;
        int burst_left;
        fsmff_pkg::out_t none;
        none = '0;
        errors = 0;
        beats_accepted = 0;
        last_page = '0;
        pages_used = '0;
        for (i = 0; i < fsmff_pkg::PAGES; i++) begin
            cat_mem[i] = '0;
            page_written[i] = 1'b0;
        end
        aresetn <= 1'b0;
        s_valid <= 1'b0;
        s_data  <= '0;

        // cmd, page, bytes, category, typed?, found, page, category, total
        dir_rows.push_back(mk_row(fsmff_pkg::CMD_GET,    0,     0,      0,    1, 0, 0, 0,   0));
        dir_rows.push_back(mk_row(fsmff_pkg::CMD_FIND,   0,     0,      0,    1, 0, 0, 0,   0));
        dir_rows.push_back(mk_row(fsmff_pkg::CMD_FIND,   4095,  65535,  255,  1, 0, 0, 0,   0));
        dir_rows.push_back(mk_row(fsmff_pkg::CMD_SET,    5,     0,      0,    1, 0, 0, 0,   6));
        dir_rows.push_back(mk_row(fsmff_pkg::CMD_FIND,   0,     0,      0,    1, 0, 0, 0,   6));
        dir_rows.push_back(mk_row(fsmff_pkg::CMD_GET,    5,     0,      0,    1, 0, 0, 0,   6));
        dir_rows.push_back(mk_row(fsmff_pkg::CMD_UPDATE, 3,     0,      0,    1, 0, 0, 0,   6));
        dir_rows.push_back(mk_row(fsmff_pkg::CMD_UPDATE, 7,     8192,   0,    1, 0, 0, 0,   8));
        dir_rows.push_back(mk_row(fsmff_pkg::CMD_FIND,   0,     1,      0,    1, 1, 7, 0,   8));
        dir_rows.push_back(mk_row(fsmff_pkg::CMD_UPDATE, 2,     65535,  0,    1, 0, 0, 0,   8));
        dir_rows.push_back(mk_row(fsmff_pkg::CMD_UPDATE, 1,     8193,   0,    0, 0, 0, 0,   0));
        dir_rows.push_back(mk_row(fsmff_pkg::CMD_UPDATE, 4,     4096,   0,    0, 0, 0, 0,   0));
        dir_rows.push_back(mk_row(fsmff_pkg::CMD_UPDATE, 6,     32,     0,    0, 0, 0, 0,   0));
        dir_rows.push_back(mk_row(fsmff_pkg::CMD_UPDATE, 8,     33,     0,    0, 0, 0, 0,   0));
        dir_rows.push_back(mk_row(fsmff_pkg::CMD_FIND,   0,     4097,   0,    0, 0, 0, 0,   0));
        dir_rows.push_back(mk_row(fsmff_pkg::CMD_SET,    1,     0,      1,    0, 0, 0, 0,   0));
        dir_rows.push_back(mk_row(fsmff_pkg::CMD_SET,    2,     0,      126,  0, 0, 0, 0,   0));
        dir_rows.push_back(mk_row(fsmff_pkg::CMD_FIND,   0,     4096,   0,    0, 0, 0, 0,   0));
        dir_rows.push_back(mk_row(fsmff_pkg::CMD_GET,    4,     0,      0,    0, 0, 0, 0,   0));
        dir_rows.push_back(mk_row(fsmff_pkg::CMD_SET,    4095,  0,      255,  1, 0, 0, 0,   4096));
        dir_rows.push_back(mk_row(fsmff_pkg::CMD_GET,    4095,  0,      0,    1, 0, 0, 255, 4096));
        dir_rows.push_back(mk_row(fsmff_pkg::CMD_FIND,   0,     8192,   0,    0, 0, 0, 0,   0));
        dir_rows.push_back(mk_row(fsmff_pkg::CMD_UPDATE, 2048,  'hAAAA, 'h55, 0, 0, 0, 0,   0));
        dir_rows.push_back(mk_row(fsmff_pkg::CMD_SET,    'hAAA, 'h5555, 'hAA, 0, 0, 0, 0,   0));
        dir_rows.push_back(mk_row(fsmff_pkg::CMD_GET,    'h555, 'hFFFF, 'hFF, 1, 0, 0, 0,   4096));

        repeat (7) @(negedge aclk);
        aresetn <= 1'b1;

        foreach (dir_rows[i]) begin
            send_beat(dir_rows[i].beat, dir_rows[i].known, dir_rows[i].reply);
            if ($urandom_range(0, 2) == 0)
                idle_gap($urandom_range(1, 6));
        end

        burst_left = 0;
        for (i = 0; i < RANDOM_BEATS; i++) begin
            if (i == DRAIN_AT) begin
                idle_gap(1);
                while (pending_replies.size() != 0) @(posedge aclk);
            end
            if (burst_left == 0) begin
                burst_left = $urandom_range(1, 20);
                if ($urandom_range(0, 9) >= 3)
                    idle_gap($urandom_range(1, 15));
            end
            send_beat(random_beat(), 1'b0, none);
            burst_left--;
        end
        idle_gap(1);

        while (pending_replies.size() != 0) @(posedge aclk);
        repeat (TAIL_CYCLES) @(posedge aclk);
        if (errors == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

    initial begin
        #5_000_000;
        $display("Verification failed");
        $finish;
    end

endmodule
